// ----- rtl/round_robin_quantum_scheduler_macros.svh -----
// Assertion helpers for the scheduler RTL.
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define RRQS_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define RRQS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- rtl/rrqs_pkg.sv -----
package rrqs_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int DATA_W   = 16;
  localparam int Q_W      = 8;
  localparam int CLK_W    = 21;
  localparam int RES_W    = 21;

  localparam logic [CLK_W-1:0] CLOCK_MAX   = 21'd1048575;
  localparam logic [Q_W-1:0]   QUANTUM_RST = 8'd4;

  // Request kinds carried on the input tuser
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  // Register index of the quantum
  localparam logic REG_QUANTUM = 1'b0;

  // Job table write port
  typedef struct packed {
    logic              en;
    logic              load;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] arr;
    logic [DATA_W-1:0] bur;
    logic [DATA_W-1:0] rem;
  } tbl_wr_t;

  // Job table registered read data
  typedef struct packed {
    logic [DATA_W-1:0] arr;
    logic [DATA_W-1:0] bur;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] arr_nxt;
  } tbl_rd_t;

endpackage

// ----- rtl/round_robin_quantum_scheduler.sv -----
// A request passes the input register, then the result register. Throughput: one request
// per cycle unless m_tready stalls the result register; the job table memory reads the
// entry for the next request in the same cycle that the current one updates the state.
// Reset (rst, synchronous): counts, pointer and clock clear, quantum returns to 4,
// both pipeline stages empty. Table contents stay undefined until loaded.
`include "round_robin_quantum_scheduler_macros.svh"

module round_robin_quantum_scheduler (
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] arrival_time, [31:16] burst_time
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [0] accepted, [4:1] job_index, [12:5] slice_length,
                                 // [13] job_finished, [34:14] turnaround,
                                 // [55:35] waiting, [56] all_done, [63:57] zero
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrqs_pkg::*;

  // Configuration
  logic [Q_W-1:0] quantum;

  // Input stage
  logic              in_valid;
  logic [1:0]        in_req;
  logic [DATA_W-1:0] in_arr;
  logic [DATA_W-1:0] in_bur;

  // Scheduler state
  logic [CNT_W-1:0] job_count, job_count_next;
  logic [CNT_W-1:0] unfinished_count, unfinished_count_next;
  logic [IDX_W-1:0] current_entry, current_entry_next;
  logic [CLK_W-1:0] elapsed_clock, elapsed_clock_next;

  // Result stage
  logic             out_accepted;
  logic [IDX_W-1:0] out_index;
  logic [Q_W-1:0]   out_slice;
  logic             out_finished;
  logic [RES_W-1:0] out_turnaround;
  logic [RES_W-1:0] out_waiting;
  logic             out_all_done;

  // Datapath
  logic                    adv;
  logic                    fire;
  tbl_wr_t                 wr;
  tbl_rd_t                 rd;
  logic [Q_W-1:0]          q_eff;
  logic [Q_W-1:0]          slice;
  logic [DATA_W-1:0]       rem_new;
  logic [CLK_W:0]          clk_sum;
  logic [CLK_W-1:0]        clk_new;
  logic signed [RES_W:0]   tat_wide;
  logic signed [RES_W:0]   wt_wide;
  logic [CNT_W-1:0]        nxt_entry;
  logic                    r_accepted;
  logic [IDX_W-1:0]        r_index;
  logic [Q_W-1:0]          r_slice;
  logic                    r_finished;
  logic [RES_W-1:0]        r_turnaround;
  logic [RES_W-1:0]        r_waiting;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUANTUM) ? {24'd0, quantum} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_QUANTUM) begin
      quantum <= pwdata[Q_W-1:0];
    end
  end

  // Handshake: the input stage moves whenever the result register is free
  assign adv      = !m_tvalid || m_tready;
  assign fire     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req <= s_tuser;
      in_arr <= s_tdata[15:0];
      in_bur <= s_tdata[31:16];
    end
  end

  // Step arithmetic on the current entry
  always_comb begin
    q_eff = (quantum == '0) ? Q_W'(1) : quantum;
    slice = (rd.rem < DATA_W'(q_eff)) ? rd.rem[Q_W-1:0] : q_eff;
    rem_new = rd.rem - DATA_W'(slice);
    clk_sum = {1'b0, elapsed_clock} + (CLK_W+1)'(slice);
    clk_new = (clk_sum > (CLK_W+1)'(CLOCK_MAX)) ? CLOCK_MAX : clk_sum[CLK_W-1:0];
    tat_wide = $signed({1'b0, clk_new}) - $signed((RES_W+1)'(rd.arr));
    wt_wide  = tat_wide - $signed((RES_W+1)'(rd.bur));
    nxt_entry = {1'b0, current_entry} + CNT_W'(1);
  end

  // Decide the request
  always_comb begin
    job_count_next        = job_count;
    unfinished_count_next = unfinished_count;
    current_entry_next    = current_entry;
    elapsed_clock_next    = elapsed_clock;
    wr                    = '0;
    wr.arr                = in_arr;
    wr.bur                = in_bur;
    r_accepted            = 1'b0;
    r_index               = '0;
    r_slice               = '0;
    r_finished            = 1'b0;
    r_turnaround          = '0;
    r_waiting             = '0;
    if (fire) begin
      case (in_req)
        REQ_CLEAR: begin
          job_count_next        = '0;
          unfinished_count_next = '0;
          current_entry_next    = '0;
          elapsed_clock_next    = '0;
          r_accepted            = 1'b1;
        end
        REQ_LOAD: begin
          if (job_count < CNT_W'(MAX_JOBS) && in_bur != '0) begin
            wr.en                 = 1'b1;
            wr.load               = 1'b1;
            wr.addr               = job_count[IDX_W-1:0];
            wr.rem                = in_bur;
            r_index               = job_count[IDX_W-1:0];
            job_count_next        = job_count + CNT_W'(1);
            unfinished_count_next = unfinished_count + CNT_W'(1);
            r_accepted            = 1'b1;
          end
        end
        REQ_STEP: begin
          if (unfinished_count != '0 && {1'b0, current_entry} < job_count) begin
            r_accepted = 1'b1;
            r_index    = current_entry;
            r_slice    = slice;
            wr.en      = 1'b1;
            wr.addr    = current_entry;
            wr.rem     = rem_new;
            elapsed_clock_next = clk_new;
            if (rd.rem != '0 && rem_new == '0) begin
              r_finished            = 1'b1;
              unfinished_count_next = unfinished_count - CNT_W'(1);
              r_turnaround          = tat_wide[RES_W-1:0];
              r_waiting             = wt_wide[RES_W-1:0];
            end
            // Advance only to an entry that has already arrived
            if (nxt_entry >= job_count) begin
              current_entry_next = '0;
            end else if (CLK_W'(rd.arr_nxt) <= clk_new) begin
              current_entry_next = nxt_entry[IDX_W-1:0];
            end else begin
              current_entry_next = '0;
            end
          end
        end
        default: begin
          r_accepted = 1'b0;
        end
      endcase
    end
  end

  // Hold scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      job_count        <= '0;
      unfinished_count <= '0;
      current_entry    <= '0;
      elapsed_clock    <= '0;
    end else begin
      job_count        <= job_count_next;
      unfinished_count <= unfinished_count_next;
      current_entry    <= current_entry_next;
      elapsed_clock    <= elapsed_clock_next;
    end
  end

  rrqs_job_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (current_entry_next),
    .rd      (rd)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_accepted   <= r_accepted;
      out_index      <= r_index;
      out_slice      <= r_slice;
      out_finished   <= r_finished;
      out_turnaround <= r_turnaround;
      out_waiting    <= r_waiting;
      out_all_done   <= (unfinished_count_next == '0);
    end
  end

  assign m_tdata = {7'd0, out_all_done, out_waiting, out_turnaround, out_finished,
                    out_slice, out_index, out_accepted};

  // Checks
  `RRQS_ASSERT_NOW(a_unfinished_le_jobs, 1'b1, unfinished_count <= job_count, "unfinished count exceeds job count")
  `RRQS_ASSERT_NOW(a_jobs_le_max, 1'b1, job_count <= CNT_W'(MAX_JOBS), "job count exceeds table size")
  `RRQS_ASSERT_NOW(a_entry_in_table, current_entry != '0, {1'b0, current_entry} < job_count, "pointer beyond loaded jobs")
  `RRQS_ASSERT_NOW(a_clock_sat, 1'b1, elapsed_clock <= CLOCK_MAX, "clock above saturation limit")
  `RRQS_ASSERT_NEXT(a_finish_accepted, fire && r_finished, out_finished && out_accepted, "finished result not marked accepted")

endmodule

// ----- rtl/rrqs_job_table.sv -----
module rrqs_job_table (
  input  logic                           clk,
  input  rrqs_pkg::tbl_wr_t              wr,
  input  logic [rrqs_pkg::IDX_W-1:0]     rd_addr,
  output rrqs_pkg::tbl_rd_t              rd
);
  import rrqs_pkg::*;

  logic [DATA_W-1:0] arr_mem [MAX_JOBS];
  logic [DATA_W-1:0] bur_mem [MAX_JOBS];
  logic [DATA_W-1:0] rem_mem [MAX_JOBS];
  logic [IDX_W-1:0]  nxt_addr;

  assign nxt_addr = rd_addr + IDX_W'(1);

  // Write: a load fills the whole entry, a step updates the remaining count
  always_ff @(posedge clk) begin
    if (wr.en) begin
      rem_mem[wr.addr] <= wr.rem;
      if (wr.load) begin
        arr_mem[wr.addr] <= wr.arr;
        bur_mem[wr.addr] <= wr.bur;
      end
    end
  end

  // Registered read of the current entry and the arrival of the one after it;
  // forward a same-cycle write so the next item sees fresh data
  always_ff @(posedge clk) begin
    rd.rem <= (wr.en && wr.addr == rd_addr) ? wr.rem : rem_mem[rd_addr];
    rd.arr <= (wr.en && wr.load && wr.addr == rd_addr) ? wr.arr : arr_mem[rd_addr];
    rd.bur <= (wr.en && wr.load && wr.addr == rd_addr) ? wr.bur : bur_mem[rd_addr];
    rd.arr_nxt <= (wr.en && wr.load && wr.addr == nxt_addr) ? wr.arr
                                                           : arr_mem[nxt_addr];
  end

endmodule
